### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is released
`define AFHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define AFHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/afhd_pkg.sv
// ---------------------------------------------------------------------------
// afhd_pkg
// types, codes and constants of the frame header decoder
// ---------------------------------------------------------------------------
package afhd_pkg;

    localparam int unsigned IN_DATA_W  = 240;
    localparam int unsigned OUT_DATA_W = 144;
    localparam int unsigned OUT_USER_W = 5;

    // header as packed on the input stream, head_low in the low bits
    typedef struct packed {
        logic [15:0] avail;
        logic [63:0] ext_bytes;
        logic [31:0] head_tail;
        logic [63:0] head_mid;
        logic [63:0] head_low;
    } t_hdr;

    typedef enum logic [2:0] {
        ST_NEED_MORE = 3'd0,
        ST_CSUM_BAD  = 3'd1,
        ST_OK        = 3'd2,
        ST_BAD_EXT   = 3'd3,
        ST_BAD_CODEC = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FK_VIDEO = 2'd0,
        FK_AUDIO = 2'd1,
        FK_DATA  = 2'd2
    } t_frame_kind;

    typedef enum logic [2:0] {
        SK_I        = 3'd0,
        SK_P        = 3'd1,
        SK_B        = 3'd2,
        SK_ANALYSIS = 3'd3,
        SK_NONE     = 3'd4
    } t_sub_kind;

    // output codec codes for video
    localparam logic [1:0] VC_MPEG4     = 2'd0;
    localparam logic [1:0] VC_VEND_H264 = 2'd1;
    localparam logic [1:0] VC_H264      = 2'd2;

    // bytes advanced by the caller
    localparam logic [4:0] CONS_NONE  = 5'd0;
    localparam logic [4:0] CONS_SYNC  = 5'd4;
    localparam logic [4:0] CONS_SKIP  = 5'd5;
    localparam logic [4:0] CONS_FRAME = 5'd20;

    // sync letters folded into one checksum seed
    localparam logic [7:0] SYNC_0 = 8'h44;
    localparam logic [7:0] SYNC_1 = 8'h48;
    localparam logic [7:0] SYNC_2 = 8'h41;
    localparam logic [7:0] SYNC_3 = 8'h56;
    localparam logic [7:0] CSUM_SEED = SYNC_0 + SYNC_1 + SYNC_2 + SYNC_3;

    localparam logic [7:0] TYPE_I     = 8'hFD;
    localparam logic [7:0] TYPE_P     = 8'hFC;
    localparam logic [7:0] TYPE_B     = 8'hFE;
    localparam logic [7:0] TYPE_AUDIO = 8'hF0;
    localparam logic [7:0] TYPE_DATA  = 8'hF1;
    localparam logic [7:0] DATA_ANALYSIS = 8'h05;

    localparam logic [7:0] EXT_MARK_A = 8'h80;
    localparam logic [7:0] EXT_MARK_B = 8'h81;

    localparam logic [7:0] ENC_MPEG4     = 8'd1;
    localparam logic [7:0] ENC_VEND_H264 = 8'd2;
    localparam logic [7:0] ENC_H264      = 8'd8;

    localparam logic [7:0] AUD_CODEC_OLD = 8'd10;
    localparam logic [7:0] AUD_CODEC_NEW = 8'd22;

    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [31:0] HDR_OVERHEAD = 32'd32;

    typedef struct packed {
        t_status     status;
        t_frame_kind frame_kind;
        t_sub_kind   sub_kind;
        logic [7:0]  codec;
        logic [10:0] width;
        logic [10:0] height;
        logic [7:0]  rate_or_channels;
        logic [1:0]  scan_mode;
        logic [31:0] date_word;
        logic [31:0] frame_number;
        logic [31:0] payload_length;
        logic [4:0]  consumed;
    } t_result;

    // sequence state update produced by one header
    typedef struct packed {
        logic        seq_we;
        logic [31:0] seq;
        logic        codec_we;
        logic [1:0]  codec;
    } t_state_upd;

endpackage

### design/afhd_csum.sv
// ---------------------------------------------------------------------------
// afhd_csum
// 8-bit additive checksum over header bytes 0..18, seeded with sync letters
// ---------------------------------------------------------------------------
module afhd_csum (
    input  logic [151:0] i_bytes,
    output logic [7:0]   o_sum
);

    logic [7:0] b [0:18];
    logic [7:0] s0, s1, s2, s3;

    always_comb begin
        for (int i = 0; i < 19; i++) begin
            b[i] = i_bytes[8*i +: 8];
        end
    end

    // four short groups, then one final add
    assign s0 = b[0] + b[1] + b[2] + b[3] + b[4];
    assign s1 = b[5] + b[6] + b[7] + b[8] + b[9];
    assign s2 = b[10] + b[11] + b[12] + b[13] + b[14];
    assign s3 = b[15] + b[16] + b[17] + b[18] + afhd_pkg::CSUM_SEED;

    assign o_sum = s0 + s1 + s2 + s3;

endmodule

### design/afhd_decode.sv
// ---------------------------------------------------------------------------
// afhd_decode
// classifies one header and decodes its fields and sequence state update
// ---------------------------------------------------------------------------
module afhd_decode (
    input  afhd_pkg::t_hdr       i_hdr,
    input  logic [31:0]          i_last_seq,
    input  logic [1:0]           i_last_codec,
    output afhd_pkg::t_result    o_res,
    output afhd_pkg::t_state_upd o_upd
);

    logic [7:0]  b [0:27];
    logic [7:0]  sum;
    logic [7:0]  ext_len;
    logic [31:0] fnum;
    logic [31:0] pay;
    logic [31:0] seq_ref;
    logic        short_hdr;
    logic        short_ext;
    logic        gap;

    afhd_csum u_csum (
        .i_bytes ({i_hdr.head_tail[23:0], i_hdr.head_mid, i_hdr.head_low}),
        .o_sum   (sum)
    );

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            b[i]      = i_hdr.head_low[8*i +: 8];
            b[8 + i]  = i_hdr.head_mid[8*i +: 8];
            b[20 + i] = i_hdr.ext_bytes[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            b[16 + i] = i_hdr.head_tail[8*i +: 8];
        end
    end

    assign ext_len   = b[18];
    assign fnum      = i_hdr.head_low[63:32];
    assign pay       = i_hdr.head_mid[31:0] - afhd_pkg::HDR_OVERHEAD - {24'd0, ext_len};
    assign short_hdr = i_hdr.avail < afhd_pkg::HDR_BYTES;
    assign short_ext = {1'b0, i_hdr.avail} < ({1'b0, afhd_pkg::HDR_BYTES} + {9'd0, ext_len});

    // a zero last number takes the new one before the gap test
    assign seq_ref = (i_last_seq == 32'd0) ? fnum : i_last_seq;
    assign gap     = (fnum > (seq_ref + 32'd1)) || (fnum < seq_ref);

    always_comb begin
        logic [7:0] dei;
        logic [7:0] enc;
        logic       ext_ok;

        o_res  = '0;
        o_upd  = '0;
        dei    = '0;
        enc    = '0;
        ext_ok = 1'b1;
        o_res.status     = afhd_pkg::ST_NEED_MORE;
        o_res.frame_kind = afhd_pkg::FK_VIDEO;
        o_res.sub_kind   = afhd_pkg::SK_I;

        if (short_hdr) begin
            o_res.consumed = afhd_pkg::CONS_NONE;
        end else if (sum != b[19]) begin
            o_res.status   = afhd_pkg::ST_CSUM_BAD;
            o_res.consumed = afhd_pkg::CONS_SYNC;
        end else if (short_ext) begin
            o_res.consumed = afhd_pkg::CONS_NONE;
        end else begin
            o_res.date_word      = i_hdr.head_mid[63:32];
            o_res.frame_number   = fnum;
            o_res.payload_length = pay;
            o_res.status         = afhd_pkg::ST_OK;
            o_res.consumed       = afhd_pkg::CONS_FRAME;

            if (b[0] == afhd_pkg::TYPE_I) begin
                o_upd.seq_we = 1'b1;
                o_upd.seq    = fnum;
                if (b[20] == afhd_pkg::EXT_MARK_A && b[24] == afhd_pkg::EXT_MARK_B) begin
                    o_res.width            = {b[22], 3'b000};
                    o_res.height           = {b[23], 3'b000};
                    o_res.rate_or_channels = b[27];
                    dei = b[21];
                    enc = b[26];
                end else if (b[20] == afhd_pkg::EXT_MARK_B
                             && b[24] == afhd_pkg::EXT_MARK_A) begin
                    o_res.width            = {b[26], 3'b000};
                    o_res.height           = {b[27], 3'b000};
                    o_res.rate_or_channels = b[23];
                    dei = b[25];
                    enc = b[22];
                end else begin
                    ext_ok = 1'b0;
                end

                if (!ext_ok) begin
                    o_res.status   = afhd_pkg::ST_BAD_EXT;
                    o_res.sub_kind = afhd_pkg::SK_NONE;
                    o_res.consumed = afhd_pkg::CONS_SKIP;
                end else begin
                    case (dei)
                        8'd0:    o_res.scan_mode = 2'd2;
                        8'd1:    o_res.scan_mode = 2'd1;
                        8'd2:    o_res.scan_mode = 2'd0;
                        default: o_res.scan_mode = 2'd3;
                    endcase
                    o_upd.codec_we = 1'b1;
                    case (enc)
                        afhd_pkg::ENC_MPEG4:     o_upd.codec = afhd_pkg::VC_MPEG4;
                        afhd_pkg::ENC_VEND_H264: o_upd.codec = afhd_pkg::VC_VEND_H264;
                        afhd_pkg::ENC_H264:      o_upd.codec = afhd_pkg::VC_H264;
                        default: begin
                            o_upd.codec_we = 1'b0;
                            o_upd.codec    = afhd_pkg::VC_MPEG4;
                            o_res.status   = afhd_pkg::ST_BAD_CODEC;
                            o_res.consumed = afhd_pkg::CONS_NONE;
                        end
                    endcase
                    o_res.codec = {6'd0, o_upd.codec};
                end
            end else if (b[0] == afhd_pkg::TYPE_P || b[0] == afhd_pkg::TYPE_B) begin
                o_upd.seq_we         = 1'b1;
                o_upd.seq            = fnum;
                o_res.payload_length = pay - {31'd0, gap};
                o_res.sub_kind       = (b[0] == afhd_pkg::TYPE_P) ? afhd_pkg::SK_P
                                                                  : afhd_pkg::SK_B;
                o_res.codec          = {6'd0, i_last_codec};
            end else if (b[0] == afhd_pkg::TYPE_AUDIO) begin
                o_res.frame_kind       = afhd_pkg::FK_AUDIO;
                o_res.sub_kind         = afhd_pkg::SK_NONE;
                o_res.codec            = (b[22] == afhd_pkg::AUD_CODEC_OLD)
                                         ? afhd_pkg::AUD_CODEC_NEW : b[22];
                o_res.rate_or_channels = b[21];
            end else begin
                o_res.frame_kind = afhd_pkg::FK_DATA;
                o_res.sub_kind   = (b[0] == afhd_pkg::TYPE_DATA
                                    && b[1] == afhd_pkg::DATA_ANALYSIS)
                                   ? afhd_pkg::SK_ANALYSIS : afhd_pkg::SK_NONE;
            end
        end
    end

endmodule

### design/av_frame_header_decoder.sv
// ---------------------------------------------------------------------------
// av_frame_header_decoder
// media frame header checker and field decoder, one header per beat
// ---------------------------------------------------------------------------
// usage:
//   slave channel (i_s_*) takes one header per beat: 20 header bytes, the
//   8 extension bytes and the buffered byte count, packed in i_s_tdata.
//   master channel (o_m_*) returns one result per header: status, codec,
//   size, rate, scan mode, date word, frame number, payload length and the
//   bytes to advance in o_m_tdata; frame kind and sub kind in o_m_tuser.
//   a header is held in the input register while checksum and decode run,
//   then lands in the result register, which drives the master channel.
//   throughput is one header per cycle while the receiver keeps up, set
//   by the single decode pass between the two registers; last frame
//   number and last video codec are updated as the header moves into the
//   result register.
//   reset clears both valid flags and the sequence state (codec mpeg4).
//   when the receiver stalls, the result holds and the input register
//   still fills, so at most two headers are in flight before o_s_tready
//   drops.
// ---------------------------------------------------------------------------
module av_frame_header_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // head_low[63:0], head_mid[127:64], head_tail[159:128],
    // ext_bytes[223:160], avail[239:224]
    input  logic [afhd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status[2:0], codec[10:3], width[21:11], height[32:22],
    // rate_or_channels[40:33], scan_mode[42:41], date_word[74:43],
    // frame_number[106:75], payload_length[138:107], consumed[143:139]
    output logic [afhd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // frame_kind[1:0], sub_kind[4:2]
    output logic [afhd_pkg::OUT_USER_W-1:0] o_m_tuser
);

    logic                 r_in_valid;
    afhd_pkg::t_hdr       r_in_hdr;
    logic                 r_out_valid;
    afhd_pkg::t_result    r_out_res;
    logic [31:0]          r_last_seq;
    logic [1:0]           r_last_codec;
    logic [31:0]          n_last_seq;
    logic [1:0]           n_last_codec;

    logic                 out_ready;
    logic                 advance;
    afhd_pkg::t_result    dec_res;
    afhd_pkg::t_state_upd dec_upd;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_ready;
    assign o_s_tready = !r_in_valid || out_ready;

    afhd_decode u_decode (
        .i_hdr        (r_in_hdr),
        .i_last_seq   (r_last_seq),
        .i_last_codec (r_last_codec),
        .o_res        (dec_res),
        .o_upd        (dec_upd)
    );

    always_comb begin
        n_last_seq   = r_last_seq;
        n_last_codec = r_last_codec;
        if (advance && dec_upd.seq_we) begin
            n_last_seq = dec_upd.seq;
        end
        if (advance && dec_upd.codec_we) begin
            n_last_codec = dec_upd.codec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_seq   <= '0;
            r_last_codec <= afhd_pkg::VC_MPEG4;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            r_last_seq   <= n_last_seq;
            r_last_codec <= n_last_codec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_hdr <= afhd_pkg::t_hdr'(i_s_tdata);
        end
        if (advance) begin
            r_out_res <= dec_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_res.consumed, r_out_res.payload_length,
                         r_out_res.frame_number, r_out_res.date_word,
                         r_out_res.scan_mode, r_out_res.rate_or_channels,
                         r_out_res.height, r_out_res.width, r_out_res.codec,
                         r_out_res.status};
    assign o_m_tuser  = {r_out_res.sub_kind, r_out_res.frame_kind};

endmodule

### design/afhd_checker.sv
// ---------------------------------------------------------------------------
// afhd_checker
// port-level checks of the frame header decoder
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module afhd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [143:0] o_m_tdata,
    input logic [4:0]   o_m_tuser
);

    // result register is empty after reset
    `AFHD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "valid out of reset")

    // input register is empty after reset
    `AFHD_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> o_s_tready, "not ready out of reset")

    `AFHD_ASSERT(a_stall_hold, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser),
        "stalled beat changed")

    // a good header always advances a full header
    `AFHD_ASSERT(a_ok_consumed, i_clk, i_rst_n,
        o_m_tvalid && o_m_tdata[2:0] == afhd_pkg::ST_OK |-> o_m_tdata[143:139] == afhd_pkg::CONS_FRAME,
        "ok result with wrong advance")

    // short buffer gives an all-zero result
    `AFHD_ASSERT(a_short_zero, i_clk, i_rst_n,
        o_m_tvalid && o_m_tdata[2:0] == afhd_pkg::ST_NEED_MORE |-> o_m_tdata == '0 && o_m_tuser == '0,
        "need-more result not cleared")

endmodule

bind av_frame_header_decoder afhd_checker u_afhd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
